>>> hdl/downward_level_meter_ballistics_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the downward level meter ballistics block
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DOWNWARD_LEVEL_METER_BALLISTICS_ASSERT_SVH
`define DOWNWARD_LEVEL_METER_BALLISTICS_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define DLMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define DLMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/dlmb_pkg.sv
// ----------------------------------------------------------------------------
// dlmb_pkg
// Shared types and constants of the downward level meter ballistics block.
// ----------------------------------------------------------------------------
package dlmb_pkg;

  localparam int LEVEL_W    = 16;
  localparam int DECAY_W    = 12;
  localparam int COEFF_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = LEVEL_W + COEFF_W;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF = 2'd2;

  // Register reset values
  localparam logic signed [LEVEL_W-1:0] UPPER_RST = 16'sd0;
  localparam logic [DECAY_W-1:0]        DECAY_RST = 12'd51;
  localparam logic [COEFF_W-1:0]        COEFF_RST = 16'd13107;

  // Rounding offset for the Q16.16 smoothing product
  localparam logic [PROD_W-1:0] ROUND_HALF = 32'h0000_8000;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RING,
    ST_SCAN,
    ST_TAIL,
    ST_MULT,
    ST_UPDATE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ring_rd;       // read the delay ring and capture the level
    logic tick_update;   // update trackers, write ring and window slot
    logic slot_clear_wr; // clear the window slot at the sweep counter
    logic cnt_clr;       // restart the sweep counter
    logic cnt_inc;       // advance the sweep counter
    logic scan_rd;       // read the window slot at the sweep counter
    logic acc_clr;       // restart the window minimum search
    logic mult;          // form the smoothing product
    logic load_out;      // commit window level and load the result
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic reload;        // upper value written this cycle
    logic cnt_last;      // sweep counter at the last slot
  } dp_status_t;

endpackage

>>> hdl/dlmb_ram.sv
// ----------------------------------------------------------------------------
// dlmb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dlmb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dlmb_ctrl.sv
// ----------------------------------------------------------------------------
// dlmb_ctrl
// Sequencer for one meter tick: ring read, tracker update, window sweep,
// smoothing multiply and result hand-off; also runs the slot clearing sweep.
// ----------------------------------------------------------------------------
module dlmb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dlmb_pkg::dp_status_t status_i,
  output dlmb_pkg::dp_cmd_t    cmd_o
);
  import dlmb_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_accept;

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && !status_i.reload;
  assign in_accept = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (status_i.cnt_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_accept) state_d = ST_RING;
      ST_RING:   state_d = ST_SCAN;
      ST_SCAN:   if (status_i.cnt_last) state_d = ST_TAIL;
      ST_TAIL:   state_d = ST_MULT;
      ST_MULT:   state_d = ST_UPDATE;
      ST_UPDATE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
    // Restart the clearing sweep on a reload
    if (status_i.reload) begin
      state_d = ST_CLEAR;
    end
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.slot_clear_wr = 1'b1;
        cmd_o.cnt_inc       = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.ring_rd = in_accept;
      end
      ST_RING: begin
        cmd_o.tick_update = 1'b1;
        cmd_o.cnt_clr     = 1'b1;
        cmd_o.acc_clr     = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
      end
      ST_UPDATE: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Output valid: set on load, drop once the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/dlmb_dp.sv
// ----------------------------------------------------------------------------
// dlmb_dp
// Datapath: configuration registers, delay ring, tracked and lowest minimum,
// window slot store with minimum sweep, and window smoothing.
// ----------------------------------------------------------------------------
module dlmb_dp #(
  parameter int DELAY_LENGTH = 16,
  parameter int WINDOW_SLOTS = 256
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [dlmb_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [dlmb_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic signed [dlmb_pkg::LEVEL_W-1:0]     level_in_i,
  input  dlmb_pkg::dp_cmd_t                       cmd_i,
  output dlmb_pkg::dp_status_t                    status_o,
  output logic signed [dlmb_pkg::LEVEL_W-1:0]     current_level_o,
  output logic signed [dlmb_pkg::LEVEL_W-1:0]     window_level_o,
  output logic signed [dlmb_pkg::LEVEL_W-1:0]     global_level_o,
  output logic                                    hidden_o
);
  import dlmb_pkg::*;

  localparam int DAW    = (DELAY_LENGTH > 1) ? $clog2(DELAY_LENGTH) : 1;
  localparam int WAW    = $clog2(WINDOW_SLOTS);
  localparam int SLOT_W = LEVEL_W + 1;

  localparam logic [DAW-1:0] DPTR_LAST = DAW'(DELAY_LENGTH - 1);
  localparam logic [WAW-1:0] WPTR_LAST = WAW'(WINDOW_SLOTS - 1);

  // Configuration registers
  logic signed [LEVEL_W-1:0] upper_q;
  logic [DECAY_W-1:0]        decay_q;
  logic [COEFF_W-1:0]        coeff_q;
  logic                      reload;

  // Tick state
  logic signed [LEVEL_W-1:0] level_q;
  logic [DAW-1:0]            dptr_q;
  logic [DELAY_LENGTH-1:0]   ring_vld_q;
  logic [LEVEL_W-1:0]        ring_rdata;
  logic signed [LEVEL_W-1:0] tracked_q, tracked_d;
  logic signed [LEVEL_W-1:0] lowest_q;
  logic signed [LEVEL_W-1:0] held_q, held_d;
  logic [WAW-1:0]            sptr_q;
  logic [WAW-1:0]            cnt_q;

  // Window sweep and smoothing
  logic                      scan_vld_q;
  logic                      any_q;
  logic signed [LEVEL_W-1:0] raw_q;
  logic                      lower_q;
  logic [PROD_W-1:0]         prod_q;
  logic [PROD_W-1:0]         prod_rnd;

  // Combinational tick values
  logic signed [LEVEL_W-1:0] leaving;
  logic                      snap;
  logic                      rise;
  logic signed [LEVEL_W:0]   up;
  logic signed [LEVEL_W:0]   upper_x;
  logic signed [LEVEL_W-1:0] up_sat;
  logic signed [LEVEL_W:0]   diff;
  logic signed [LEVEL_W-1:0] slot_level;
  logic                      slot_we;
  logic [WAW-1:0]            slot_waddr;
  logic [SLOT_W-1:0]         slot_wdata;
  logic [SLOT_W-1:0]         slot_rdata;

  assign reload = cfg_we_i && (cfg_idx_i == REG_UPPER);

  assign status_o.reload   = reload;
  assign status_o.cnt_last = (cnt_q == WPTR_LAST);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UPPER_RST;
      decay_q <= DECAY_RST;
      coeff_q <= COEFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UPPER: upper_q <= $signed(cfg_data_i[LEVEL_W-1:0]);
        REG_DECAY: decay_q <= cfg_data_i[DECAY_W-1:0];
        REG_COEFF: coeff_q <= cfg_data_i[COEFF_W-1:0];
        default:   upper_q <= upper_q;
      endcase
    end
  end

  // Capture the incoming level
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_rd) begin
      level_q <= level_in_i;
    end
  end

  // Delay ring storage
  dlmb_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (DELAY_LENGTH),
    .AW    (DAW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tick_update),
    .waddr_i (dptr_q),
    .wdata_i (level_q),
    .re_i    (cmd_i.ring_rd),
    .raddr_i (dptr_q),
    .rdata_o (ring_rdata)
  );

  // Level leaving the ring; unwritten entries read as the upper value
  assign leaving = ring_vld_q[dptr_q] ? $signed(ring_rdata) : upper_q;

  // Tracker: snap down, rise by the decay step, or hold on equal
  assign snap    = leaving < tracked_q;
  assign rise    = leaving > tracked_q;
  assign up      = {tracked_q[LEVEL_W-1], tracked_q} + $signed({5'b0, decay_q});
  assign upper_x = {upper_q[LEVEL_W-1], upper_q};
  assign up_sat  = (up < upper_x) ? up[LEVEL_W-1:0] : upper_q;

  always_comb begin
    tracked_d = tracked_q;
    if (snap) begin
      tracked_d = leaving;
    end else if (rise) begin
      tracked_d = up_sat;
    end
  end

  // Window slot store: tick write, clearing sweep, minimum sweep read
  assign slot_level = snap ? leaving : '0;
  assign slot_we    = cmd_i.tick_update || cmd_i.slot_clear_wr;
  assign slot_waddr = cmd_i.slot_clear_wr ? cnt_q : sptr_q;
  assign slot_wdata = cmd_i.slot_clear_wr ? '0 : {snap, slot_level};

  dlmb_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (WINDOW_SLOTS),
    .AW    (WAW)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (cnt_q),
    .rdata_o (slot_rdata)
  );

  // Tick state registers and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dptr_q     <= '0;
      ring_vld_q <= '0;
      sptr_q     <= '0;
      cnt_q      <= '0;
      tracked_q  <= UPPER_RST;
      lowest_q   <= UPPER_RST;
      scan_vld_q <= 1'b0;
    end else if (reload) begin
      dptr_q     <= '0;
      ring_vld_q <= '0;
      sptr_q     <= '0;
      cnt_q      <= '0;
      tracked_q  <= $signed(cfg_data_i[LEVEL_W-1:0]);
      lowest_q   <= $signed(cfg_data_i[LEVEL_W-1:0]);
      scan_vld_q <= 1'b0;
    end else begin
      scan_vld_q <= cmd_i.scan_rd;
      if (cmd_i.tick_update) begin
        ring_vld_q[dptr_q] <= 1'b1;
        dptr_q    <= (dptr_q == DPTR_LAST) ? '0 : dptr_q + 1'b1;
        sptr_q    <= (sptr_q == WPTR_LAST) ? '0 : sptr_q + 1'b1;
        tracked_q <= tracked_d;
        if (snap && (leaving < lowest_q)) begin
          lowest_q <= leaving;
        end
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= (cnt_q == WPTR_LAST) ? '0 : cnt_q + 1'b1;
      end
    end
  end

  // Minimum over the valid window slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (cmd_i.acc_clr) begin
      any_q <= 1'b0;
    end else if (scan_vld_q && slot_rdata[SLOT_W-1] &&
                 (!any_q || ($signed(slot_rdata[LEVEL_W-1:0]) < raw_q))) begin
      any_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_vld_q && slot_rdata[SLOT_W-1] &&
        (!any_q || ($signed(slot_rdata[LEVEL_W-1:0]) < raw_q))) begin
      raw_q <= $signed(slot_rdata[LEVEL_W-1:0]);
    end
  end

  // Smoothing product of the rise toward the window minimum
  assign diff = {raw_q[LEVEL_W-1], raw_q} - {held_q[LEVEL_W-1], held_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      lower_q <= raw_q < held_q;
      prod_q  <= PROD_W'(diff[LEVEL_W-1:0] * coeff_q);
    end
  end

  // Rounded step always fits the level width and never overshoots raw
  assign prod_rnd = prod_q + ROUND_HALF;

  always_comb begin
    held_d = held_q;
    if (any_q) begin
      if (lower_q) begin
        held_d = raw_q;
      end else begin
        held_d = held_q + $signed(prod_rnd[PROD_W-1:COEFF_W]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= UPPER_RST;
    end else if (reload) begin
      held_q <= $signed(cfg_data_i[LEVEL_W-1:0]);
    end else if (cmd_i.load_out) begin
      held_q <= held_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      current_level_o <= tracked_q;
      window_level_o  <= held_d;
      global_level_o  <= lowest_q;
      hidden_o        <= tracked_q >= upper_q;
    end
  end

endmodule

>>> hdl/downward_level_meter_ballistics.sv
// ----------------------------------------------------------------------------
// downward_level_meter_ballistics: falling-minimum level meter with decay
// Ticks are taken one at a time: a new tick is accepted only after the slot
// sweep and the result hand-off of the last one.
// Reset, and each upper_value write, runs a slot clear over all WINDOW_SLOTS slots.
// ----------------------------------------------------------------------------
`include "downward_level_meter_ballistics_assert.svh"

module downward_level_meter_ballistics #(
  parameter int DELAY_LENGTH = 16,
  parameter int WINDOW_SLOTS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dlmb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dlmb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [dlmb_pkg::LEVEL_W-1:0] level_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dlmb_pkg::LEVEL_W-1:0] current_level_o,
  output logic signed [dlmb_pkg::LEVEL_W-1:0] window_level_o,
  output logic signed [dlmb_pkg::LEVEL_W-1:0] global_level_o,
  output logic                                hidden_o
);
  import dlmb_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Tick sequencer
  dlmb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // Meter datapath
  dlmb_dp #(
    .DELAY_LENGTH (DELAY_LENGTH),
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .level_in_i      (level_in_i),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .current_level_o (current_level_o),
    .window_level_o  (window_level_o),
    .global_level_o  (global_level_o),
    .hidden_o        (hidden_o)
  );

  // One tick at a time: no accept right after an accepted transaction
  `DLMB_ASSERT_NEXT(a_one_tick, in_valid_i && in_ready_o, !in_ready_o, "second tick accepted")

  // A reload starts the clearing sweep, which blocks input
  `DLMB_ASSERT_NEXT(a_reload_clears, dp_status.reload, !in_ready_o, "input open after reload")

  // The lowest level seen bounds both the tracker and the window level
  `DLMB_ASSERT_NOW(a_global_lowest, out_valid_o, (window_level_o >= global_level_o) && (current_level_o >= global_level_o), "global level above a tracker")

endmodule

>>> dv/tb_downward_level_meter_ballistics.sv
// ----------------------------------------------------------------------------
// tb_downward_level_meter_ballistics: self-checking bench for the level meter
// Drives meter ticks over valid/ready, programs the three registers between
// phases and checks each result against its table row or a cycle-free model.
// A directed table covers the extremes first. Random phases follow under
// changing register settings, with random gaps on both sides, one long
// output stall and pauses for drain.
// ----------------------------------------------------------------------------
module tb_downward_level_meter_ballistics;
  import dlmb_pkg::*;

  localparam int DELAY_LENGTH   = 16;
  localparam int WINDOW_SLOTS   = 256;
  localparam int MAX_GAP        = 11;
  localparam int HOLD_CYCLES    = 3000;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_TICKS    = 165;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_DIRECTED   = 27;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef struct packed {
    level_t current;
    level_t window;
    level_t lowest;
    logic   hidden;
  } meter_result_t;

  typedef enum logic {
    ROW_CFG,
    ROW_LEVEL
  } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic                    typed;
    meter_result_t           want;
  } stim_row_t;

  localparam meter_result_t AT_ZERO  = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
  localparam meter_result_t AT_TOP   = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1};
  localparam meter_result_t NO_CHECK = '0;

  // Directed ticks: after reset, register extremes, reload to the top, then
  // the first levels coming out of the delay ring
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_LEVEL, REG_UPPER, 16'h0000, 1'b1, AT_ZERO},  // equal level, no rise
    '{ROW_LEVEL, REG_UPPER, 16'h8000, 1'b1, AT_ZERO},
    '{ROW_LEVEL, REG_UPPER, 16'h7FFF, 1'b1, AT_ZERO},
    '{ROW_CFG,   REG_DECAY, 16'hFFFF, 1'b0, NO_CHECK}, // step above range
    '{ROW_CFG,   REG_COEFF, 16'hFFFF, 1'b0, NO_CHECK},
    '{ROW_CFG,   REG_SPARE, 16'hFFFF, 1'b0, NO_CHECK}, // ignored index
    '{ROW_CFG,   REG_UPPER, 16'h7FFF, 1'b0, NO_CHECK}, // reload at the top
    '{ROW_LEVEL, REG_UPPER, 16'h8000, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h7FFF, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h7FFF, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'hFFFF, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h0100, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h0000, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h8001, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h7FFE, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h5555, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'hAAAA, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h8000, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h0001, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'hC000, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h3FFF, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h8000, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h7FFF, 1'b1, AT_TOP},
    '{ROW_LEVEL, REG_UPPER, 16'h0000, 1'b0, NO_CHECK}, // snap to the bottom
    '{ROW_LEVEL, REG_UPPER, 16'h8000, 1'b0, NO_CHECK},
    '{ROW_LEVEL, REG_UPPER, 16'h1234, 1'b0, NO_CHECK},
    '{ROW_LEVEL, REG_UPPER, 16'h7FFF, 1'b0, NO_CHECK}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  level_t                level_in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  level_t                current_level_o;
  level_t                window_level_o;
  level_t                global_level_o;
  logic                  hidden_o;

  downward_level_meter_ballistics #(
    .DELAY_LENGTH(DELAY_LENGTH),
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .level_in_i     (level_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .current_level_o(current_level_o),
    .window_level_o (window_level_o),
    .global_level_o (global_level_o),
    .hidden_o       (hidden_o)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Meter model state and register copies
  level_t               ring_q [DELAY_LENGTH];
  int unsigned          ring_ptr;
  level_t               track_min;
  level_t               low_seen;
  level_t               held_min;
  bit                   slot_live [WINDOW_SLOTS];
  level_t               slot_val [WINDOW_SLOTS];
  int unsigned          slot_ptr;
  level_t               upper_r;
  logic [DECAY_W-1:0]   decay_r;
  logic [COEFF_W-1:0]   coeff_r;

  meter_result_t        pending_q [$];
  int                   error_count;
  int                   results_checked;
  int                   ticks_sent;
  int                   reg_writes;
  int                   cycle_count;
  bit                   idle_on;
  bit                   hold_req;

  // Load every tracker and the ring with the upper value and clear the window
  function automatic void reload_meter();
    for (int i = 0; i < DELAY_LENGTH; i++) ring_q[i] = upper_r;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_val[i]  = '0;
    end
    ring_ptr  = 0;
    slot_ptr  = 0;
    track_min = upper_r;
    low_seen  = upper_r;
    held_min  = upper_r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_UPPER: begin
        upper_r = level_t'(data);
        reload_meter();
      end
      REG_DECAY: decay_r = data[DECAY_W-1:0];
      REG_COEFF: coeff_r = data[COEFF_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the meter by one tick and return what it shows afterwards
  function automatic meter_result_t advance_meter(level_t lvl);
    level_t        leaving;
    bit            snapped;
    bit            found;
    int            raw;
    int            up;
    longint        diff;
    longint        step;
    meter_result_t r;
    leaving         = ring_q[ring_ptr];
    ring_q[ring_ptr] = lvl;
    ring_ptr        = (ring_ptr + 1) % DELAY_LENGTH;

    // Snap down on a lower level, rise by the decay step on a higher one
    snapped = 1'b0;
    if (leaving < track_min) begin
      track_min = leaving;
      snapped   = 1'b1;
      if (leaving < low_seen) low_seen = leaving;
    end else if (leaving > track_min) begin
      up        = int'(track_min) + int'(decay_r);
      track_min = (up < int'(upper_r)) ? level_t'(up) : upper_r;
    end

    slot_live[slot_ptr] = snapped;
    slot_val[slot_ptr]  = snapped ? leaving : level_t'(0);
    slot_ptr            = (slot_ptr + 1) % WINDOW_SLOTS;

    // Take a lower window minimum at once, smooth toward a higher one
    found = 1'b0;
    raw   = 0;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      if (slot_live[i] && (!found || int'(slot_val[i]) < raw)) begin
        raw   = int'(slot_val[i]);
        found = 1'b1;
      end
    end
    if (found) begin
      if (raw < int'(held_min)) begin
        held_min = level_t'(raw);
      end else begin
        diff     = longint'(raw) - longint'(held_min);
        step     = (diff * longint'(coeff_r) + longint'(ROUND_HALF)) >>> 16;
        held_min = level_t'(int'(held_min) + int'(step));
      end
    end

    r.current = track_min;
    r.window  = held_min;
    r.lowest  = low_seen;
    r.hidden  = (track_min >= upper_r);
    return r;
  endfunction

  // Pick a level: mostly near the previous level or below the upper value so that snaps happen
  function automatic level_t pick_level(int prev);
    int v;
    int sel;
    sel = int'($urandom_range(0, 99));
    if (sel < 40) begin
      v = prev + int'($urandom_range(0, 1024)) - 512;
    end else if (sel < 60) begin
      v = int'(level_t'($urandom));
    end else if (sel < 75) begin
      case ($urandom_range(0, 3))
        0:       v = -32768;
        1:       v = 32767;
        2:       v = int'(upper_r);
        default: v = int'(upper_r) - 1;
      endcase
    end else begin
      v = int'(upper_r) - int'($urandom_range(0, 3000));
    end
    if (v < -32768) v = -32768;
    if (v > 32767)  v = 32767;
    return level_t'(v);
  endfunction

  // Offer one level transaction and record what it should produce
  task automatic send_level(level_t lvl, bit typed, meter_result_t want);
    int            gap;
    meter_result_t predicted;
    gap = idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_in_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = advance_meter(lvl);
    pending_q.push_back(typed ? want : predicted);
    ticks_sent++;
  endtask

  // Drain the block, then write one register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, data);
    reg_writes++;
    @(posedge clk_i);
  endtask

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Accept results with random back-pressure and compare with the oldest expectation
  initial begin
    int            gap;
    meter_result_t want;
    meter_result_t got;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.current = current_level_o;
      got.window  = window_level_o;
      got.lowest  = global_level_o;
      got.hidden  = hidden_o;
      if (pending_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("Result with no transaction pending: current %0d window %0d global %0d hidden %0b",
                   got.current, got.window, got.lowest, got.hidden);
      end else begin
        want = pending_q.pop_front();
        if (got.current !== want.current || got.window !== want.window ||
            got.lowest !== want.lowest || got.hidden !== want.hidden) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("Mismatch on result %0d (expected/actual): current %0d/%0d window %0d/%0d global %0d/%0d hidden %0b/%0b",
                     results_checked, want.current, got.current, want.window, got.window,
                     want.lowest, got.lowest, want.hidden, got.hidden);
        end
      end
      results_checked++;
    end
  end

  // Reset, directed table, random phases, drain and verdict
  initial begin
    level_t             lvl;
    level_t             upper_pick;
    logic [DECAY_W-1:0] decay_pick;
    logic [COEFF_W-1:0] coeff_pick;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    level_in_i      = '0;
    out_ready_i     = 1'b0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    error_count     = 0;
    results_checked = 0;
    ticks_sent      = 0;
    reg_writes      = 0;
    cycle_count     = 0;
    upper_r         = UPPER_RST;
    decay_r         = DECAY_RST;
    coeff_r         = COEFF_RST;
    reload_meter();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int n = 0; n < NUM_DIRECTED; n++) begin
      if (DIRECTED[n].kind == ROW_CFG)
        write_reg(DIRECTED[n].idx, DIRECTED[n].data);
      else
        send_level(level_t'(DIRECTED[n].data), DIRECTED[n].typed, DIRECTED[n].want);
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          upper_pick = 16'sh8000;
          decay_pick = '0;
          coeff_pick = '0;
        end
        1: begin
          upper_pick = 16'sh7FFF;
          decay_pick = '1;
          coeff_pick = '1;
        end
        2: begin
          upper_pick = 16'sd0;
          decay_pick = 12'd2560;
          coeff_pick = COEFF_RST;
        end
        default: begin
          upper_pick = level_t'($urandom);
          decay_pick = ($urandom_range(0, 3) == 0) ? DECAY_W'($urandom)
                                                   : DECAY_W'($urandom_range(0, 2560));
          coeff_pick = COEFF_W'($urandom);
        end
      endcase
      // Keep the running state across some phases by not reloading
      if (phase % 4 != 3) write_reg(REG_UPPER, CFG_DATA_W'(upper_pick));
      write_reg(REG_DECAY, {4'($urandom), decay_pick});
      write_reg(REG_COEFF, coeff_pick);
      if (phase == 4) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      idle_on = (phase % 3 != 2);

      lvl = upper_r;
      for (int k = 0; k < PHASE_TICKS; k++) begin
        // Stall the output for a long stretch while ticks keep coming
        if (phase == 5 && k == 3) hold_req = 1'b1;
        // Pause the input until the block has drained
        if (k == PHASE_TICKS / 2) begin
          in_valid_i <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk_i);
        end
        lvl = pick_level(int'(lvl));
        send_level(lvl, 1'b0, NO_CHECK);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (WINDOW_SLOTS + 8) @(posedge clk_i);

    $display("Checked %0d results from %0d level transactions (%0d directed rows)",
             results_checked, ticks_sent, NUM_DIRECTED);
    $display("Register writes: %0d over %0d random settings, %0d failures",
             reg_writes, NUM_PHASES, error_count);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
